// ----- rtl/hctp_pkg.sv -----
package hctp_pkg;

  // Result status codes
  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StBadNum = 2'd1;
  localparam logic [1:0] StNoPfx  = 2'd2;
  localparam logic [1:0] StBadHex = 2'd3;

  // Color reported when a token has no hex part
  localparam logic [31:0] NoColor = 32'h00FF_FFFF;

  // Character codes
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChX     = 8'h78;

  // Byte classification handed from the classifier to the parser
  typedef struct packed {
    logic       is_sep;
    logic       is_minus;
    logic       is_comma;
    logic       is_zero;
    logic       is_x;
    logic       is_dec;
    logic       is_hex;
    logic [3:0] hex_val;
  } char_class_t;

endpackage

// ----- rtl/hctp_if.sv -----
interface hctp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface hctp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] height;
  logic        [31:0] color;
  logic        [1:0]  status;

  modport source (output valid, output height, output color, output status, input ready);
  modport sink   (input valid, input height, input color, input status, output ready);
endinterface

// ----- rtl/hctp_classify.sv -----
module hctp_classify (
  input  logic [7:0]                ch_i,
  output hctp_pkg::char_class_t     cls_o
);

  logic is_lc_hex;
  logic is_uc_hex;

  assign is_lc_hex = (ch_i >= 8'h61) && (ch_i <= 8'h66);
  assign is_uc_hex = (ch_i >= 8'h41) && (ch_i <= 8'h46);

  always_comb begin
    cls_o.is_sep   = (ch_i == hctp_pkg::ChSpace) || (ch_i == hctp_pkg::ChNl);
    cls_o.is_minus = (ch_i == hctp_pkg::ChMinus);
    cls_o.is_comma = (ch_i == hctp_pkg::ChComma);
    cls_o.is_zero  = (ch_i == hctp_pkg::ChZero);
    cls_o.is_x     = (ch_i == hctp_pkg::ChX);
    cls_o.is_dec   = (ch_i >= 8'h30) && (ch_i <= 8'h39);
    cls_o.is_hex   = cls_o.is_dec || is_lc_hex || is_uc_hex;
    // letters a-f / A-F: low nibble 1..6 maps to 10..15
    if (cls_o.is_dec) begin
      cls_o.hex_val = ch_i[3:0];
    end else if (is_lc_hex || is_uc_hex) begin
      cls_o.hex_val = ch_i[3:0] + 4'd9;
    end else begin
      cls_o.hex_val = 4'd0;
    end
  end

endmodule

// ----- rtl/height_color_token_parser.sv -----
// Token parser for map text: one byte per item in, one result per ended token out.
// A separator passes the input stage, then the result register. One byte per cycle
// unless a separator waits on a full result slot; the per-byte update (multiply by
// ten or sixteen plus a digit) is one short combinational step between registers.
// Reset (rst_ni low, asynchronous): parser returns to start of token, pipeline empty.
module height_color_token_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  hctp_in_if.sink           in_i,
  hctp_out_if.source        out_o
);

  typedef enum logic [2:0] {
    PhIdle,
    PhMinus,
    PhDec,
    PhComma,
    PhZero,
    PhHex,
    PhErr
  } phase_e;

  // Input stage: one byte held
  logic       s1_valid_q;
  logic [7:0] s1_ch_q;

  // Token state
  phase_e      phase_q, phase_d;
  logic        neg_q, neg_d;
  logic [31:0] hacc_q, hacc_d;
  logic [31:0] cacc_q, cacc_d;
  logic        has_color_q, has_color_d;
  logic        open_q, open_d;
  logic [1:0]  err_q, err_d;

  // Result register
  logic        out_valid_q;
  logic [31:0] out_height_q;
  logic [31:0] out_color_q;
  logic [1:0]  out_status_q;

  hctp_pkg::char_class_t cls;

  logic        out_free;
  logic        s1_fire;
  logic        emit;
  logic [1:0]  st;
  logic [31:0] res_height;
  logic [31:0] res_color;

  hctp_classify u_classify (
    .ch_i  (s1_ch_q),
    .cls_o (cls)
  );

  // Result slot can take a new item when empty or being drained this cycle
  assign out_free = !out_valid_q || out_o.ready;
  // Non-separator bytes never need the result slot
  assign s1_fire  = s1_valid_q && (!cls.is_sep || out_free);
  assign in_i.ready = !s1_valid_q || s1_fire;

  assign out_o.valid  = out_valid_q;
  assign out_o.height = out_height_q;
  assign out_o.color  = out_color_q;
  assign out_o.status = out_status_q;

  // Status at token end
  always_comb begin
    case (phase_q)
      PhDec, PhHex:     st = hctp_pkg::StOk;
      PhMinus:          st = hctp_pkg::StBadNum;
      PhComma, PhZero:  st = hctp_pkg::StNoPfx;
      default:          st = err_q;
    endcase
  end

  always_comb begin
    if (st == hctp_pkg::StOk) begin
      res_height = neg_q ? (32'd0 - hacc_q) : hacc_q;
      res_color  = has_color_q ? cacc_q : hctp_pkg::NoColor;
    end else begin
      res_height = 32'd0;
      res_color  = 32'd0;
    end
  end

  // A separator only gives a result when a token is open
  assign emit = s1_fire && cls.is_sep && open_q;

  // Next token state
  always_comb begin
    phase_d     = phase_q;
    neg_d       = neg_q;
    hacc_d      = hacc_q;
    cacc_d      = cacc_q;
    has_color_d = has_color_q;
    open_d      = open_q;
    err_d       = err_q;
    if (s1_fire) begin
      if (cls.is_sep) begin
        phase_d     = PhIdle;
        neg_d       = 1'b0;
        hacc_d      = 32'd0;
        cacc_d      = 32'd0;
        has_color_d = 1'b0;
        open_d      = 1'b0;
        err_d       = hctp_pkg::StOk;
      end else begin
        open_d = 1'b1;
        case (phase_q)
          PhIdle: begin
            if (cls.is_minus) begin
              phase_d = PhMinus;
            end else if (cls.is_dec) begin
              hacc_d  = {28'd0, s1_ch_q[3:0]};
              phase_d = PhDec;
            end else if (cls.is_comma) begin
              phase_d = PhComma;
            end else begin
              err_d   = hctp_pkg::StBadNum;
              phase_d = PhErr;
            end
          end
          PhMinus: begin
            if (cls.is_dec) begin
              neg_d   = 1'b1;
              hacc_d  = {28'd0, s1_ch_q[3:0]};
              phase_d = PhDec;
            end else begin
              err_d   = hctp_pkg::StBadNum;
              phase_d = PhErr;
            end
          end
          PhDec: begin
            if (cls.is_dec) begin
              // acc * 10 + digit
              hacc_d = (hacc_q << 3) + (hacc_q << 1) + {28'd0, s1_ch_q[3:0]};
            end else if (cls.is_comma) begin
              phase_d = PhComma;
            end else begin
              err_d   = hctp_pkg::StBadNum;
              phase_d = PhErr;
            end
          end
          PhComma: begin
            if (cls.is_zero) begin
              phase_d = PhZero;
            end else begin
              err_d   = hctp_pkg::StNoPfx;
              phase_d = PhErr;
            end
          end
          PhZero: begin
            if (cls.is_x) begin
              has_color_d = 1'b1;
              cacc_d      = 32'd0;
              phase_d     = PhHex;
            end else begin
              err_d   = hctp_pkg::StNoPfx;
              phase_d = PhErr;
            end
          end
          PhHex: begin
            if (cls.is_hex) begin
              cacc_d = {cacc_q[27:0], cls.hex_val};
            end else begin
              err_d   = hctp_pkg::StBadHex;
              phase_d = PhErr;
            end
          end
          default: begin
            phase_d = PhErr;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      phase_q     <= PhIdle;
      neg_q       <= 1'b0;
      hacc_q      <= 32'd0;
      cacc_q      <= 32'd0;
      has_color_q <= 1'b0;
      open_q      <= 1'b0;
      err_q       <= hctp_pkg::StOk;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      phase_q     <= phase_d;
      neg_q       <= neg_d;
      hacc_q      <= hacc_d;
      cacc_q      <= cacc_d;
      has_color_q <= has_color_d;
      open_q      <= open_d;
      err_q       <= err_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_ch_q <= in_i.ch;
    end
    if (emit) begin
      out_height_q <= res_height;
      out_color_q  <= res_color;
      out_status_q <= st;
    end
  end

endmodule
